// File: src/rmsb_pkg.sv
// ----------------------------------------------------------------------------
// rmsb_pkg
// Shared types and constants for the block-minimum range query engine.
// ----------------------------------------------------------------------------
package rmsb_pkg;

  // Array geometry and field widths
  localparam int MAX_ELEMENTS       = 1024;
  localparam int BLOCK_SIZE_DEFAULT = 32;
  localparam int IDX_W              = $clog2(MAX_ELEMENTS);
  localparam int CNT_W              = $clog2(MAX_ELEMENTS + 1);
  localparam int DATA_W             = 32;
  localparam int APB_DATA_W         = 32;
  localparam int PADDR_W            = 3;

  localparam logic signed [DATA_W-1:0] LARGEST_VALUE = 32'sh7FFF_FFFF;
  localparam logic [CNT_W-1:0]         COUNT_RESET   = CNT_W'(MAX_ELEMENTS);

  // Register index decoded from paddr[PADDR_W-1]
  localparam logic REG_ELEMENT_COUNT = 1'b0;

  // Operation codes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [IDX_W-1:0]         index;
    logic [IDX_W-1:0]         right_index;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] min_value;
    logic                     status;
  } out_item_t;

  // Control of the shared compare unit
  typedef struct packed {
    logic init;     // load accumulator with init value
    logic fold;     // fold read data into accumulator
    logic src_blk;  // read data comes from block minima memory
  } minu_ctl_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_UPD_WR,
    ST_SCAN_A,
    ST_SCAN_B,
    ST_SCAN_C,
    ST_DRAIN,
    ST_DONE
  } seq_state_t;

endpackage

// File: src/range_minimum_sqrt_blocks.sv
// ----------------------------------------------------------------------------
// range_minimum_sqrt_blocks
// Range-minimum engine over a 1024-entry signed array with block minima.
// ----------------------------------------------------------------------------
// One transaction is in flight at a time; in_ready is high only between
// transactions. A query scans its left block's elements from its index,
// then, if the ends lie in different blocks, its right block's elements up
// to its right index, then the minima of the whole blocks between; an
// invalid query goes straight to its result. A query also holds in its last
// state while the output register is full and out_ready is low. The engine
// uses one shared compare unit fed by one read per cycle from the element
// RAM or the block minima RAM. After reset all MAX_ELEMENTS/BLOCK_SIZE
// entries (32 by default) of the block minima RAM are swept to the largest
// value before the first transaction is taken; configuration writes are
// taken during the sweep.
// ----------------------------------------------------------------------------
module range_minimum_sqrt_blocks #(
  parameter int BLOCK_SIZE = rmsb_pkg::BLOCK_SIZE_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  rmsb_pkg::in_item_t                    in_data,
  // Result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output rmsb_pkg::out_item_t                   out_data,
  // Configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rmsb_pkg::PADDR_W-1:0]          paddr,
  input  logic [rmsb_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [rmsb_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  localparam int NUM_BLOCKS = rmsb_pkg::MAX_ELEMENTS / BLOCK_SIZE;
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = rmsb_pkg::CNT_W;

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    wr_count;
  logic                cfg_wr;

  logic                out_vld_r, out_vld_nxt;
  rmsb_pkg::out_item_t out_data_r, out_data_nxt;
  logic                slot_free;
  logic                res_push;
  rmsb_pkg::out_item_t res_data;

  rmsb_pkg::minu_ctl_t                 ctl;
  logic signed [rmsb_pkg::DATA_W-1:0]  init_value;
  logic signed [rmsb_pkg::DATA_W-1:0]  acc;

  logic                          elem_we;
  logic [rmsb_pkg::IDX_W-1:0]    elem_waddr;
  logic [rmsb_pkg::DATA_W-1:0]   elem_wdata;
  logic [rmsb_pkg::IDX_W-1:0]    elem_raddr;
  logic [rmsb_pkg::DATA_W-1:0]   elem_rdata;
  logic                          bmin_we;
  logic [BLK_W-1:0]              bmin_waddr;
  logic [rmsb_pkg::DATA_W-1:0]   bmin_wdata;
  logic [BLK_W-1:0]              bmin_raddr;
  logic [rmsb_pkg::DATA_W-1:0]   bmin_rdata;

  // Element count register, saturated to the array size
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready &&
                    (paddr[rmsb_pkg::PADDR_W-1] == rmsb_pkg::REG_ELEMENT_COUNT);
  assign wr_count = pwdata[CNT_W-1:0];

  always_comb begin
    count_nxt = count_r;
    if (cfg_wr) begin
      count_nxt = (wr_count > rmsb_pkg::COUNT_RESET) ? rmsb_pkg::COUNT_RESET : wr_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= rmsb_pkg::COUNT_RESET;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign prdata = (paddr[rmsb_pkg::PADDR_W-1] == rmsb_pkg::REG_ELEMENT_COUNT) ?
                  {{(rmsb_pkg::APB_DATA_W-CNT_W){1'b0}}, count_r} : '0;

  // Output register: hold result until taken
  assign slot_free = !out_vld_r || out_ready;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    if (res_push) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = res_data;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // Sequencer
  rmsb_seq #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_ready   (in_ready),
    .elem_count (count_r),
    .slot_free  (slot_free),
    .res_push   (res_push),
    .res_data   (res_data),
    .acc        (acc),
    .ctl        (ctl),
    .init_value (init_value),
    .elem_we    (elem_we),
    .elem_waddr (elem_waddr),
    .elem_wdata (elem_wdata),
    .elem_raddr (elem_raddr),
    .bmin_we    (bmin_we),
    .bmin_waddr (bmin_waddr),
    .bmin_wdata (bmin_wdata),
    .bmin_raddr (bmin_raddr)
  );

  // Shared compare unit
  rmsb_min_unit u_min (
    .clk        (clk),
    .ctl        (ctl),
    .init_value (init_value),
    .elem_rdata (elem_rdata),
    .bmin_rdata (bmin_rdata),
    .acc        (acc)
  );

  // Element storage
  rmsb_ram #(
    .DEPTH (rmsb_pkg::MAX_ELEMENTS),
    .WIDTH (rmsb_pkg::DATA_W)
  ) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (elem_wdata),
    .raddr (elem_raddr),
    .rdata (elem_rdata)
  );

  // Block minima storage
  rmsb_ram #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (rmsb_pkg::DATA_W)
  ) u_bmin_ram (
    .clk   (clk),
    .we    (bmin_we),
    .waddr (bmin_waddr),
    .wdata (bmin_wdata),
    .raddr (bmin_raddr),
    .rdata (bmin_rdata)
  );

endmodule

// File: src/rmsb_ram.sv
// ----------------------------------------------------------------------------
// rmsb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rmsb_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/rmsb_min_unit.sv
// ----------------------------------------------------------------------------
// rmsb_min_unit
// Shared signed compare unit with a running-minimum accumulator.
// ----------------------------------------------------------------------------
module rmsb_min_unit (
  input  logic                                clk,
  input  rmsb_pkg::minu_ctl_t                 ctl,
  input  logic signed [rmsb_pkg::DATA_W-1:0]  init_value,
  input  logic [rmsb_pkg::DATA_W-1:0]         elem_rdata,
  input  logic [rmsb_pkg::DATA_W-1:0]         bmin_rdata,
  output logic signed [rmsb_pkg::DATA_W-1:0]  acc
);

  logic signed [rmsb_pkg::DATA_W-1:0] din;
  logic signed [rmsb_pkg::DATA_W-1:0] acc_r;
  logic signed [rmsb_pkg::DATA_W-1:0] acc_nxt;

  // Select the memory that was read last cycle
  assign din = ctl.src_blk ? $signed(bmin_rdata) : $signed(elem_rdata);

  // Load or fold the running minimum
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.init) begin
      acc_nxt = init_value;
    end else if (ctl.fold && (din < acc_r)) begin
      acc_nxt = din;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// File: src/rmsb_seq.sv
// ----------------------------------------------------------------------------
// rmsb_seq
// Sequencer: clears block minima, walks element and block ranges one read
// per cycle, writes back block minima and hands off query results.
// ----------------------------------------------------------------------------
module rmsb_seq #(
  parameter int BLOCK_SIZE  = rmsb_pkg::BLOCK_SIZE_DEFAULT,
  localparam int NUM_BLOCKS = rmsb_pkg::MAX_ELEMENTS / BLOCK_SIZE,
  localparam int OFF_W      = $clog2(BLOCK_SIZE),
  localparam int BLK_W      = $clog2(NUM_BLOCKS)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input transactions
  input  logic                                in_valid,
  input  rmsb_pkg::in_item_t                  in_data,
  output logic                                in_ready,
  // Configuration
  input  logic [rmsb_pkg::CNT_W-1:0]          elem_count,
  // Result hand-off
  input  logic                                slot_free,
  output logic                                res_push,
  output rmsb_pkg::out_item_t                 res_data,
  // Compare unit
  input  logic signed [rmsb_pkg::DATA_W-1:0]  acc,
  output rmsb_pkg::minu_ctl_t                 ctl,
  output logic signed [rmsb_pkg::DATA_W-1:0]  init_value,
  // Element memory
  output logic                                elem_we,
  output logic [rmsb_pkg::IDX_W-1:0]          elem_waddr,
  output logic [rmsb_pkg::DATA_W-1:0]         elem_wdata,
  output logic [rmsb_pkg::IDX_W-1:0]          elem_raddr,
  // Block minima memory
  output logic                                bmin_we,
  output logic [BLK_W-1:0]                    bmin_waddr,
  output logic [rmsb_pkg::DATA_W-1:0]         bmin_wdata,
  output logic [BLK_W-1:0]                    bmin_raddr
);

  localparam int IDX_W = rmsb_pkg::IDX_W;
  localparam int CNT_W = rmsb_pkg::CNT_W;
  localparam logic [IDX_W-1:0] OFF_MASK  = IDX_W'(BLOCK_SIZE - 1);
  localparam logic [BLK_W-1:0] LAST_BLK  = BLK_W'(NUM_BLOCKS - 1);

  rmsb_pkg::seq_state_t state_r, state_nxt;
  logic [1:0]               op_r, op_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [IDX_W-1:0]         ridx_r, ridx_nxt;
  logic signed [rmsb_pkg::DATA_W-1:0] val_r, val_nxt;
  logic                     err_r, err_nxt;
  logic [IDX_W-1:0]         cur_r, cur_nxt;
  logic [IDX_W-1:0]         last_r, last_nxt;
  logic                     rd_vld_r, rd_vld_nxt;
  logic                     rd_src_r, rd_src_nxt;

  logic [IDX_W-1:0] in_blk_start;
  logic [IDX_W-1:0] in_blk_end;
  logic [IDX_W-1:0] upd_last;
  logic [CNT_W-1:0] cnt_m1;
  logic [BLK_W-1:0] in_lb;
  logic [BLK_W-1:0] in_rb;
  logic             wr_ok;
  logic             q_err;
  logic [BLK_W-1:0] lb_r_blk;
  logic [BLK_W-1:0] rb_r_blk;
  logic [BLK_W-1:0] blk_gap;
  logic             scan_end;

  // Decode the offered item
  assign in_blk_start = in_data.index & ~OFF_MASK;
  assign in_blk_end   = in_data.index | OFF_MASK;
  assign cnt_m1       = elem_count - CNT_W'(1);
  assign upd_last     = ({1'b0, in_blk_end} >= elem_count) ? IDX_W'(cnt_m1) : in_blk_end;
  assign in_lb        = in_data.index[IDX_W-1 -: BLK_W];
  assign in_rb        = in_data.right_index[IDX_W-1 -: BLK_W];
  assign wr_ok        = ({1'b0, in_data.index} < elem_count);
  assign q_err        = (in_data.index > in_data.right_index) ||
                        ({1'b0, in_data.right_index} >= elem_count);

  // Held item geometry
  assign lb_r_blk = idx_r[IDX_W-1 -: BLK_W];
  assign rb_r_blk = ridx_r[IDX_W-1 -: BLK_W];
  assign blk_gap  = rb_r_blk - lb_r_blk;
  assign scan_end = (cur_r == last_r);

  // State and item registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rmsb_pkg::ST_CLEAR;
      cur_r    <= '0;
      rd_vld_r <= 1'b0;
      err_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      rd_vld_r <= rd_vld_nxt;
      err_r    <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    idx_r    <= idx_nxt;
    ridx_r   <= ridx_nxt;
    val_r    <= val_nxt;
    last_r   <= last_nxt;
    rd_src_r <= rd_src_nxt;
  end

  // Next state and outputs
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    idx_nxt     = idx_r;
    ridx_nxt    = ridx_r;
    val_nxt     = val_r;
    err_nxt     = err_r;
    cur_nxt     = cur_r;
    last_nxt    = last_r;
    rd_vld_nxt  = 1'b0;
    rd_src_nxt  = rd_src_r;
    in_ready    = 1'b0;
    res_push    = 1'b0;
    ctl.init    = 1'b0;
    ctl.fold    = rd_vld_r;
    ctl.src_blk = rd_src_r;
    init_value  = rmsb_pkg::LARGEST_VALUE;
    elem_we     = 1'b0;
    elem_waddr  = idx_r;
    elem_wdata  = val_r;
    elem_raddr  = cur_r;
    bmin_we     = 1'b0;
    bmin_waddr  = lb_r_blk;
    bmin_wdata  = acc;
    bmin_raddr  = cur_r[BLK_W-1:0];

    unique case (state_r)
      // Sweep block minima to the largest value after reset
      rmsb_pkg::ST_CLEAR: begin
        bmin_we    = 1'b1;
        bmin_waddr = cur_r[BLK_W-1:0];
        bmin_wdata = rmsb_pkg::LARGEST_VALUE;
        if (cur_r[BLK_W-1:0] == LAST_BLK) begin
          cur_nxt   = '0;
          state_nxt = rmsb_pkg::ST_IDLE;
        end else begin
          cur_nxt = cur_r + IDX_W'(1);
        end
      end

      // Take a transaction and set up its range
      rmsb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt     = in_data.opcode;
          idx_nxt    = in_data.index;
          ridx_nxt   = in_data.right_index;
          val_nxt    = in_data.value;
          err_nxt    = 1'b0;
          ctl.init   = 1'b1;
          if (in_data.opcode == rmsb_pkg::OP_LOAD) begin
            init_value = in_data.value;
          end
          unique case (in_data.opcode)
            rmsb_pkg::OP_LOAD: begin
              if (wr_ok) begin
                state_nxt = rmsb_pkg::ST_LOAD;
              end
            end
            rmsb_pkg::OP_UPDATE: begin
              if (wr_ok) begin
                cur_nxt   = in_blk_start;
                last_nxt  = upd_last;
                state_nxt = rmsb_pkg::ST_UPD_WR;
              end
            end
            rmsb_pkg::OP_QUERY: begin
              if (q_err) begin
                err_nxt   = 1'b1;
                state_nxt = rmsb_pkg::ST_DONE;
              end else begin
                cur_nxt   = in_data.index;
                last_nxt  = (in_lb == in_rb) ? in_data.right_index : in_blk_end;
                state_nxt = rmsb_pkg::ST_SCAN_A;
              end
            end
            default: begin
              // Unused opcode: drop
            end
          endcase
        end
      end

      // Write element and fetch its block minimum for folding
      rmsb_pkg::ST_LOAD: begin
        elem_we    = 1'b1;
        bmin_raddr = lb_r_blk;
        rd_vld_nxt = 1'b1;
        rd_src_nxt = 1'b1;
        state_nxt  = rmsb_pkg::ST_DRAIN;
      end

      // Write element before rescanning its block
      rmsb_pkg::ST_UPD_WR: begin
        elem_we   = 1'b1;
        state_nxt = rmsb_pkg::ST_SCAN_A;
      end

      // Scan first element range
      rmsb_pkg::ST_SCAN_A: begin
        rd_vld_nxt = 1'b1;
        rd_src_nxt = 1'b0;
        if (scan_end) begin
          if ((op_r == rmsb_pkg::OP_QUERY) && (lb_r_blk != rb_r_blk)) begin
            cur_nxt   = ridx_r & ~OFF_MASK;
            last_nxt  = ridx_r;
            state_nxt = rmsb_pkg::ST_SCAN_B;
          end else begin
            state_nxt = rmsb_pkg::ST_DRAIN;
          end
        end else begin
          cur_nxt = cur_r + IDX_W'(1);
        end
      end

      // Scan partial right block
      rmsb_pkg::ST_SCAN_B: begin
        rd_vld_nxt = 1'b1;
        rd_src_nxt = 1'b0;
        if (scan_end) begin
          if (blk_gap > BLK_W'(1)) begin
            cur_nxt   = {{OFF_W{1'b0}}, lb_r_blk + BLK_W'(1)};
            last_nxt  = {{OFF_W{1'b0}}, rb_r_blk - BLK_W'(1)};
            state_nxt = rmsb_pkg::ST_SCAN_C;
          end else begin
            state_nxt = rmsb_pkg::ST_DRAIN;
          end
        end else begin
          cur_nxt = cur_r + IDX_W'(1);
        end
      end

      // Scan whole blocks through their minima
      rmsb_pkg::ST_SCAN_C: begin
        rd_vld_nxt = 1'b1;
        rd_src_nxt = 1'b1;
        if (scan_end) begin
          state_nxt = rmsb_pkg::ST_DRAIN;
        end else begin
          cur_nxt = cur_r + IDX_W'(1);
        end
      end

      // Let the last read fold in
      rmsb_pkg::ST_DRAIN: begin
        state_nxt = rmsb_pkg::ST_DONE;
      end

      // Write back block minimum or hand off the query result
      rmsb_pkg::ST_DONE: begin
        if (op_r == rmsb_pkg::OP_QUERY) begin
          if (slot_free) begin
            res_push  = 1'b1;
            state_nxt = rmsb_pkg::ST_IDLE;
          end
        end else begin
          bmin_we   = 1'b1;
          state_nxt = rmsb_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = rmsb_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_data.min_value = acc;
  assign res_data.status    = err_r;

endmodule
